>>> src/esl_pkg.sv
// Shared types and constants for the exponent sieve block.
// Used by the controller, the datapath and the top level; depends on nothing.
package esl_pkg;

    // Default size of the survivor map.
    localparam int ESL_MAX_EXPONENTS = 16384;

    // Field widths.
    localparam int ESL_DIV_W     = 22;
    localparam int ESL_CMD_W     = 2;
    localparam int ESL_CNT_W     = 15;
    localparam int ESL_EXP_W     = 14;
    localparam int ESL_DIGIT_W   = 6;
    localparam int ESL_WORD_W    = 32;
    localparam int ESL_CFG_IDX_W = 3;
    localparam int ESL_NB_W      = 6;

    // Request command codes.
    localparam logic [ESL_CMD_W-1:0] ESL_CMD_START = 2'd0;
    localparam logic [ESL_CMD_W-1:0] ESL_CMD_SIEVE = 2'd1;
    localparam logic [ESL_CMD_W-1:0] ESL_CMD_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [ESL_CFG_IDX_W-1:0] ESL_REG_BASE   = 3'd0;
    localparam logic [ESL_CFG_IDX_W-1:0] ESL_REG_DIGIT  = 3'd1;
    localparam logic [ESL_CFG_IDX_W-1:0] ESL_REG_PREFIX = 3'd2;
    localparam logic [ESL_CFG_IDX_W-1:0] ESL_REG_SUFFIX = 3'd3;
    localparam logic [ESL_CFG_IDX_W-1:0] ESL_REG_SCALE  = 3'd4;
    localparam logic [ESL_CFG_IDX_W-1:0] ESL_REG_MIN    = 3'd5;
    localparam logic [ESL_CFG_IDX_W-1:0] ESL_REG_MAX    = 3'd6;

    typedef struct packed {
        logic [ESL_CMD_W-1:0] command;
        logic [ESL_DIV_W-1:0] divisor;
    } esl_req_t;

    typedef struct packed {
        logic [ESL_CNT_W-1:0] removed_count;
        logic [ESL_CNT_W-1:0] remaining_count;
        logic [ESL_EXP_W-1:0] exponent;
        logic                 exponent_valid;
    } esl_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_cmd;
        logic addr_zero;
        logic addr_from_ptr;
        logic addr_inc;
        logic total_zero;
        logic ptr_zero;
        logic sweep_write;
        logic sweep_mark;
        logic op_zero;
        logic pre_load;
        logic pre_store;
        logic sv_load;
        logic sv_commit;
        logic rd_found;
        logic res_load;
    } esl_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ESL_CMD_W-1:0] command;
        logic                 divisor_small;
        logic                 addr_last;
        logic                 addr_end;
        logic                 op_last;
        logic                 mm_done;
        logic                 map_bit;
    } esl_sts_t;

endpackage

>>> src/exponent_sieve_linear_family.sv
// Start request: one survivor map entry written per cycle.
// Sieve request: after a short precompute, the shared modular unit steps through each
// exponent one base bit at a time and then commits it.
// Read request: scans map entries forward from the read pointer to a survivor or the end.
// One request at a time; the next is taken while the previous result waits.
// After reset a clearing pass over every map entry runs with cmd_stall held high.
//
// Top level of the exponent sieve: joins controller and datapath.
// Depends on esl_pkg, esl_ctrl and esl_datapath.
module exponent_sieve_linear_family #(
    parameter int MAX_EXPONENTS = esl_pkg::ESL_MAX_EXPONENTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [esl_pkg::ESL_CFG_IDX_W-1:0]   cfg_index,
    input  logic [esl_pkg::ESL_WORD_W-1:0]      cfg_data,
    // Request channel.
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  esl_pkg::esl_req_t                   cmd,
    // Result channel.
    output logic                                res_valid,
    input  logic                                res_stall,
    output esl_pkg::esl_res_t                   res
);

    // The controller sequences each request: sweeps of the survivor map for
    // start and for the clearing pass, the residue precompute and the
    // per-exponent walk for a sieve, and the forward scan for a read. The
    // datapath holds the registers, the map memory and the modular unit, and
    // owns the result register, so a finished result can wait for the far
    // side while the next request is already accepted.
    esl_pkg::esl_ctl_t ctl;
    esl_pkg::esl_sts_t sts;

    esl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // A sieve keeps w = v(n) * scale mod p and steps it as w*base + digit*scale,
    // so the test for each exponent is a single add and compare against p.
    esl_datapath #(
        .MAX_EXPONENTS (MAX_EXPONENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (cmd),
        .ctl       (ctl),
        .sts       (sts),
        .res       (res)
    );

endmodule

>>> src/esl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the survivor map.
module esl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/esl_modmul.sv
// Iterative modular multiply-add: result = (a * x + c) mod p, one bit of x a cycle.
// Depends on esl_pkg for widths; a and c must already be below p.
module esl_modmul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic [esl_pkg::ESL_DIV_W-1:0]       a,
    input  logic [esl_pkg::ESL_DIV_W-1:0]       c,
    input  logic [esl_pkg::ESL_WORD_W-1:0]      x,
    input  logic [esl_pkg::ESL_NB_W-1:0]        nbits,
    input  logic [esl_pkg::ESL_DIV_W-1:0]       p,
    output logic                                done,
    output logic [esl_pkg::ESL_DIV_W-1:0]       result
);

    localparam int DIV_W = esl_pkg::ESL_DIV_W;

    logic [DIV_W-1:0]               r_reg, r_next;
    logic [DIV_W-1:0]               m_reg, m_next;
    logic [esl_pkg::ESL_WORD_W-1:0] x_reg, x_next;
    logic [esl_pkg::ESL_NB_W-1:0]   cnt_reg, cnt_next;

    // Sum of two residues, folded back below p with one subtraction.
    function automatic logic [DIV_W-1:0] add_mod(input logic [DIV_W-1:0] lhs,
                                                 input logic [DIV_W-1:0] rhs,
                                                 input logic [DIV_W-1:0] modulus);
        logic [DIV_W:0] s;
        s = {1'b0, lhs} + {1'b0, rhs};
        if (s >= {1'b0, modulus})
        begin
            s = s - {1'b0, modulus};
        end
        return s[DIV_W-1:0];
    endfunction

    always_comb
    begin
        r_next   = r_reg;
        m_next   = m_reg;
        x_next   = x_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            r_next   = c;
            m_next   = a;
            x_next   = x;
            cnt_next = nbits;
        end
        else if (cnt_reg != '0)
        begin
            if (x_reg[0])
            begin
                r_next = add_mod(r_reg, m_reg, p);
            end
            m_next   = add_mod(m_reg, m_reg, p);
            x_next   = x_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        m_reg <= m_next;
        x_reg <= x_next;
    end

    assign done   = (cnt_reg == '0);
    assign result = r_reg;

endmodule

>>> src/esl_datapath.sv
// Datapath of the exponent sieve: registers, survivor map, counters and modular unit.
// Depends on esl_pkg, esl_ram and esl_modmul; driven by esl_ctrl.
module esl_datapath #(
    parameter int MAX_EXPONENTS = esl_pkg::ESL_MAX_EXPONENTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [esl_pkg::ESL_CFG_IDX_W-1:0]   cfg_index,
    input  logic [esl_pkg::ESL_WORD_W-1:0]      cfg_data,
    input  esl_pkg::esl_req_t                   req,
    input  esl_pkg::esl_ctl_t                   ctl,
    output esl_pkg::esl_sts_t                   sts,
    output esl_pkg::esl_res_t                   res
);

    localparam int ADDR_W  = (MAX_EXPONENTS > 1) ? $clog2(MAX_EXPONENTS) : 1;
    localparam int CW      = $clog2(MAX_EXPONENTS + 1);
    localparam int DIV_W   = esl_pkg::ESL_DIV_W;
    localparam int WORD_W  = esl_pkg::ESL_WORD_W;
    localparam int DIGIT_W = esl_pkg::ESL_DIGIT_W;
    localparam int EXP_W   = esl_pkg::ESL_EXP_W;
    localparam int OCNT_W  = esl_pkg::ESL_CNT_W;
    localparam int NB_W    = esl_pkg::ESL_NB_W;

    // Precompute steps, in the order they run.
    localparam logic [2:0] OP_BASE   = 3'd0;
    localparam logic [2:0] OP_DIGIT  = 3'd1;
    localparam logic [2:0] OP_SCALE  = 3'd2;
    localparam logic [2:0] OP_SUFFIX = 3'd3;
    localparam logic [2:0] OP_PREFIX = 3'd4;
    localparam logic [2:0] OP_DSC    = 3'd5;
    localparam logic [2:0] OP_W0     = 3'd6;

    // Configuration registers.
    logic [DIGIT_W-1:0] base_reg;
    logic [DIGIT_W-1:0] digit_reg;
    logic [WORD_W-1:0]  prefix_reg;
    logic [WORD_W-1:0]  suffix_reg;
    logic [WORD_W-1:0]  scale_reg;
    logic [EXP_W-1:0]   min_reg;
    logic [EXP_W-1:0]   max_reg;

    // Request and control state.
    logic [esl_pkg::ESL_CMD_W-1:0] command_reg;
    logic [DIV_W-1:0]              divisor_reg;
    logic [CW-1:0]                 addr_reg, addr_next;
    logic [CW-1:0]                 ptr_reg;
    logic [CW-1:0]                 total_reg;
    logic [CW-1:0]                 removed_reg;
    logic                          found_reg;
    logic [EXP_W-1:0]              exp_reg;
    logic [2:0]                    op_reg;

    // Residues modulo the divisor.
    logic [DIV_W-1:0] bm_reg;
    logic [DIV_W-1:0] dm_reg;
    logic [DIV_W-1:0] scm_reg;
    logic [DIV_W-1:0] sfm_reg;
    logic [DIV_W-1:0] pm_reg;
    logic [DIV_W-1:0] dsc_reg;
    logic [DIV_W-1:0] w_reg;

    esl_pkg::esl_res_t res_reg;

    logic              mm_load;
    logic [DIV_W-1:0]  mm_a;
    logic [DIV_W-1:0]  mm_c;
    logic [WORD_W-1:0] mm_x;
    logic [NB_W-1:0]   mm_nb;
    logic              mm_done;
    logic [DIV_W-1:0]  mm_result;

    logic              mem_we;
    logic [0:0]        mem_wdata;
    logic [0:0]        rd_data;
    logic              in_range;
    logic              mark_one;
    logic [DIV_W:0]    check_sum;
    logic              hit;
    logic              remove;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= DIGIT_W'(10);
            digit_reg  <= '0;
            prefix_reg <= '0;
            suffix_reg <= '0;
            scale_reg  <= WORD_W'(1);
            min_reg    <= EXP_W'(2);
            max_reg    <= EXP_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esl_pkg::ESL_REG_BASE:   base_reg   <= cfg_data[DIGIT_W-1:0];
                esl_pkg::ESL_REG_DIGIT:  digit_reg  <= cfg_data[DIGIT_W-1:0];
                esl_pkg::ESL_REG_PREFIX: prefix_reg <= cfg_data;
                esl_pkg::ESL_REG_SUFFIX: suffix_reg <= cfg_data;
                esl_pkg::ESL_REG_SCALE:  scale_reg  <= cfg_data;
                esl_pkg::ESL_REG_MIN:    min_reg    <= cfg_data[EXP_W-1:0];
                esl_pkg::ESL_REG_MAX:    max_reg    <= cfg_data[EXP_W-1:0];
                default: ;
            endcase
        end
    end

    // The full number v*scale + suffix is divisible when w + suffix mod p is 0 or p.
    assign check_sum = {1'b0, w_reg} + {1'b0, sfm_reg};
    assign hit       = rd_data[0] && ((check_sum == '0) || (check_sum == {1'b0, divisor_reg}));
    assign remove    = ctl.sv_commit && hit;

    assign in_range  = (WORD_W'(addr_reg) >= WORD_W'(min_reg))
                    && (WORD_W'(addr_reg) <= WORD_W'(max_reg));
    assign mark_one  = ctl.sweep_write && ctl.sweep_mark && in_range;
    assign mem_we    = ctl.sweep_write || remove;
    assign mem_wdata = mark_one;

    always_comb
    begin
        addr_next = addr_reg;
        if (ctl.addr_zero)
        begin
            addr_next = '0;
        end
        else if (ctl.addr_from_ptr)
        begin
            addr_next = ptr_reg;
        end
        else if (ctl.addr_inc)
        begin
            addr_next = addr_reg + 1'b1;
        end
    end

    // The map is read at the next address every cycle, so its output always
    // shows the entry under the current address.
    esl_ram #(
        .WIDTH (1),
        .DEPTH (MAX_EXPONENTS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_reg[ADDR_W-1:0]),
        .wdata (mem_wdata),
        .raddr (addr_next[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        mm_load = ctl.pre_load || ctl.sv_load || ctl.sv_commit;
        mm_a    = DIV_W'(1);
        mm_c    = '0;
        mm_x    = '0;
        mm_nb   = NB_W'(DIGIT_W);
        if (ctl.sv_commit)
        begin
            mm_a = mm_result;
            mm_c = dsc_reg;
            mm_x = WORD_W'(bm_reg[DIGIT_W-1:0]);
        end
        else if (ctl.sv_load)
        begin
            mm_a = w_reg;
            mm_c = dsc_reg;
            mm_x = WORD_W'(bm_reg[DIGIT_W-1:0]);
        end
        else
        begin
            case (op_reg)
                OP_BASE:   mm_x = WORD_W'(base_reg);
                OP_DIGIT:  mm_x = WORD_W'(digit_reg);
                OP_SCALE:
                begin
                    mm_x  = scale_reg;
                    mm_nb = NB_W'(WORD_W);
                end
                OP_SUFFIX:
                begin
                    mm_x  = suffix_reg;
                    mm_nb = NB_W'(WORD_W);
                end
                OP_PREFIX:
                begin
                    mm_x  = prefix_reg;
                    mm_nb = NB_W'(WORD_W);
                end
                OP_DSC:
                begin
                    mm_a  = dm_reg;
                    mm_x  = WORD_W'(scm_reg);
                    mm_nb = NB_W'(DIV_W);
                end
                OP_W0:
                begin
                    mm_a  = pm_reg;
                    mm_x  = WORD_W'(scm_reg);
                    mm_nb = NB_W'(DIV_W);
                end
                default: ;
            endcase
        end
    end

    esl_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (mm_load),
        .a      (mm_a),
        .c      (mm_c),
        .x      (mm_x),
        .nbits  (mm_nb),
        .p      (divisor_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg <= '0;
            addr_reg    <= '0;
            ptr_reg     <= '0;
            total_reg   <= '0;
            removed_reg <= '0;
            found_reg   <= 1'b0;
            exp_reg     <= '0;
            op_reg      <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
            if (ctl.take_cmd)
            begin
                command_reg <= req.command;
                removed_reg <= '0;
                found_reg   <= 1'b0;
                exp_reg     <= '0;
            end
            else if (remove)
            begin
                removed_reg <= removed_reg + 1'b1;
            end
            if (ctl.total_zero)
            begin
                total_reg <= '0;
            end
            else if (mark_one)
            begin
                total_reg <= total_reg + 1'b1;
            end
            else if (remove)
            begin
                total_reg <= total_reg - 1'b1;
            end
            if (ctl.ptr_zero)
            begin
                ptr_reg <= '0;
            end
            else if (ctl.rd_found)
            begin
                ptr_reg <= addr_reg + 1'b1;
            end
            if (ctl.rd_found)
            begin
                found_reg <= 1'b1;
                exp_reg   <= EXP_W'(addr_reg);
            end
            if (ctl.op_zero)
            begin
                op_reg <= '0;
            end
            else if (ctl.pre_store)
            begin
                op_reg <= op_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take_cmd)
        begin
            divisor_reg <= req.divisor;
        end
        if (ctl.pre_store)
        begin
            case (op_reg)
                OP_BASE:   bm_reg  <= mm_result;
                OP_DIGIT:  dm_reg  <= mm_result;
                OP_SCALE:  scm_reg <= mm_result;
                OP_SUFFIX: sfm_reg <= mm_result;
                OP_PREFIX: pm_reg  <= mm_result;
                OP_DSC:    dsc_reg <= mm_result;
                OP_W0:     w_reg   <= mm_result;
                default: ;
            endcase
        end
        else if (ctl.sv_commit)
        begin
            w_reg <= mm_result;
        end
        if (ctl.res_load)
        begin
            res_reg.removed_count   <= OCNT_W'(removed_reg);
            res_reg.remaining_count <= OCNT_W'(total_reg);
            res_reg.exponent        <= exp_reg;
            res_reg.exponent_valid  <= found_reg;
        end
    end

    assign sts.command       = command_reg;
    assign sts.divisor_small = (divisor_reg < DIV_W'(2));
    assign sts.addr_last     = (addr_reg == CW'(MAX_EXPONENTS - 1));
    assign sts.addr_end      = (addr_reg == CW'(MAX_EXPONENTS));
    assign sts.op_last       = (op_reg == OP_W0);
    assign sts.mm_done       = mm_done;
    assign sts.map_bit       = rd_data[0];

    assign res = res_reg;

endmodule

>>> src/esl_ctrl.sv
// Controller state machine of the exponent sieve.
// Depends on esl_pkg; drives esl_datapath through command and status structs.
module esl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    output logic              res_valid,
    input  logic              res_stall,
    input  esl_pkg::esl_sts_t sts,
    output esl_pkg::esl_ctl_t ctl
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_START    = 4'd3;
    localparam logic [3:0] S_PRE_LOAD = 4'd4;
    localparam logic [3:0] S_PRE_RUN  = 4'd5;
    localparam logic [3:0] S_SV_FIRST = 4'd6;
    localparam logic [3:0] S_SV_RUN   = 4'd7;
    localparam logic [3:0] S_RD_SCAN  = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       res_valid_reg, res_valid_next;

    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        res_valid_next = res_valid_reg && res_stall;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.sweep_write = 1'b1;
                ctl.addr_inc    = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.take_cmd = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.command)
                    esl_pkg::ESL_CMD_START:
                    begin
                        ctl.addr_zero  = 1'b1;
                        ctl.total_zero = 1'b1;
                        ctl.ptr_zero   = 1'b1;
                        state_next     = S_START;
                    end
                    esl_pkg::ESL_CMD_SIEVE:
                    begin
                        if (sts.divisor_small)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.addr_zero = 1'b1;
                            ctl.op_zero   = 1'b1;
                            state_next    = S_PRE_LOAD;
                        end
                    end
                    esl_pkg::ESL_CMD_READ:
                    begin
                        ctl.addr_from_ptr = 1'b1;
                        state_next        = S_RD_SCAN;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_START:
            begin
                ctl.sweep_write = 1'b1;
                ctl.sweep_mark  = 1'b1;
                ctl.addr_inc    = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_PRE_LOAD:
            begin
                ctl.pre_load = 1'b1;
                state_next   = S_PRE_RUN;
            end
            S_PRE_RUN:
            begin
                if (sts.mm_done)
                begin
                    ctl.pre_store = 1'b1;
                    state_next    = sts.op_last ? S_SV_FIRST : S_PRE_LOAD;
                end
            end
            S_SV_FIRST:
            begin
                ctl.sv_load = 1'b1;
                state_next  = S_SV_RUN;
            end
            S_SV_RUN:
            begin
                if (sts.mm_done)
                begin
                    ctl.sv_commit = 1'b1;
                    if (sts.addr_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctl.addr_inc = 1'b1;
                    end
                end
            end
            S_RD_SCAN:
            begin
                if (sts.addr_end)
                begin
                    state_next = S_DONE;
                end
                else if (sts.map_bit)
                begin
                    ctl.rd_found = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctl.addr_inc = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    ctl.res_load   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

endmodule
